@@ hw/rtl/pss_pkg.sv @@
// Shared types and codes for the positional sequence store.
`timescale 1ns / 1ps

package pss_pkg;

  // Widest slot index for the largest supported capacity (64 slots).
  localparam int IDX_W = 6;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_READ_FWD  = 3'd6,
    ACT_READ_REV  = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BELOW  = 3'd1,
    ST_BEYOND = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_t;

  // Broadcast to every cell: shift request and the slot it starts at.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/pss_cell.sv @@
// One storage cell of the sequence chain.
`timescale 1ns / 1ps

module pss_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  pss_pkg::cell_ctrl_t ctrl,
  input  logic signed [31:0]  new_value,
  input  logic signed [31:0]  left_value,
  input  logic signed [31:0]  right_value,
  output logic signed [31:0]  value
);

  localparam logic [pss_pkg::IDX_W-1:0] MY_IDX = pss_pkg::IDX_W'(CELL_IDX);

  // Take the new value at the insert slot, open a gap behind it, or close one.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX == ctrl.idx) begin
        value <= new_value;
      end else if (MY_IDX > ctrl.idx) begin
        value <= left_value;
      end
    end else if (ctrl.del && (MY_IDX >= ctrl.idx)) begin
      value <= right_value;
    end
  end

endmodule

@@ hw/rtl/positional_sequence_store_core.sv @@
// Top level of the positional sequence store: cell chain, control and result register.
`timescale 1ns / 1ps

// Ordered store of up to CAPACITY signed 32-bit values held in a row of cells,
// slot 0 at the front. On an insert or delete every cell behind the
// affected slot copies its neighbour in the same edge, and one result with last
// set is registered. A forward or reverse read then streams one value per cycle
// while the result register is free (up to 16 values) from the cell chosen by a
// read counter, last on the final one; a read of an empty store gives one result
// with status empty. The input is refused while a read is streaming or while the
// result register is still occupied and not being taken, so a read of a non-empty
// store blocks the input until its last value is registered. Stored values have
// no reset; only the state, count, result valid and read counters are cleared.
module positional_sequence_store_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[36:32], zero pad[39:37]
  input  logic [2:0]  s_tuser,   // action[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_value[31:0], length[36:32], zero pad[39:37]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int XW   = pss_pkg::IDX_W;
  localparam int MAXR = (CAPACITY < 16) ? CAPACITY : 16;
  localparam int PW   = ((CW > 5) ? CW : 5) + 1;

  logic signed [31:0] vals [CAPACITY];

  pss_pkg::fsm_t       state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       rd_k, rd_k_next;
  logic [CW-1:0]       rd_n, rd_n_next;
  logic                rd_rev, rd_rev_next;
  logic                out_valid, out_valid_next;
  pss_pkg::status_t    out_status, out_status_next;
  logic signed [31:0]  out_value, out_value_next;
  logic                out_last, out_last_next;
  logic [4:0]          out_len, out_len_next;

  pss_pkg::cell_ctrl_t ctrl;
  pss_pkg::action_t    act;
  logic signed [31:0]  in_value;
  logic [4:0]          in_pos;
  logic [PW-1:0]       pos_w, count_w;
  logic                slot_free, accept;
  logic [CW-1:0]       rd_slot_w;
  logic [IW-1:0]       rd_slot;

  assign act       = pss_pkg::action_t'(s_tuser);
  assign in_value  = s_tdata[31:0];
  assign in_pos    = s_tdata[36:32];
  assign pos_w     = PW'(in_pos);
  assign count_w   = PW'(count);

  // The result register is free when empty or being taken this cycle.
  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == pss_pkg::FSM_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  // Read address: count up from the front, or down from the back.
  assign rd_slot_w = rd_rev ? (count - CW'(1) - rd_k) : rd_k;
  assign rd_slot   = IW'(rd_slot_w);

  // The chain: each cell sees its neighbours; the ends see themselves.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pss_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_value   (in_value),
      .left_value  (vals[(i == 0) ? 0 : i - 1]),
      .right_value (vals[(i == CAPACITY - 1) ? i : i + 1]),
      .value       (vals[i])
    );
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    rd_k_next       = rd_k;
    rd_n_next       = rd_n;
    rd_rev_next     = rd_rev;
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_last_next   = out_last;
    out_len_next    = out_len;
    ctrl.ins        = 1'b0;
    ctrl.del        = 1'b0;
    ctrl.idx        = '0;

    case (state)
      pss_pkg::FSM_IDLE: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          out_status_next = pss_pkg::ST_OK;
          out_value_next  = '0;
          out_last_next   = 1'b1;
          case (act)
            pss_pkg::ACT_INS_FRONT, pss_pkg::ACT_INS_BACK: begin
              if (count == CW'(CAPACITY)) begin
                out_status_next = pss_pkg::ST_FULL;
              end else begin
                ctrl.ins = 1'b1;
                ctrl.idx = (act == pss_pkg::ACT_INS_FRONT) ? '0 : XW'(count);
              end
            end
            pss_pkg::ACT_INS_AT: begin
              if (in_pos == 5'd0) begin
                out_status_next = pss_pkg::ST_BELOW;
              end else if (pos_w > count_w + PW'(1)) begin
                out_status_next = pss_pkg::ST_BEYOND;
              end else if (count == CW'(CAPACITY)) begin
                out_status_next = pss_pkg::ST_FULL;
              end else begin
                ctrl.ins = 1'b1;
                ctrl.idx = XW'(in_pos - 5'd1);
              end
            end
            pss_pkg::ACT_DEL_FRONT, pss_pkg::ACT_DEL_BACK: begin
              if (count == '0) begin
                out_status_next = pss_pkg::ST_EMPTY;
              end else begin
                ctrl.del = 1'b1;
                ctrl.idx = (act == pss_pkg::ACT_DEL_FRONT) ? '0 : XW'(count - CW'(1));
              end
            end
            pss_pkg::ACT_DEL_AT: begin
              if (count == '0) begin
                out_status_next = pss_pkg::ST_EMPTY;
              end else if (in_pos == 5'd0) begin
                out_status_next = pss_pkg::ST_BELOW;
              end else if (pos_w > count_w) begin
                out_status_next = pss_pkg::ST_BEYOND;
              end else begin
                ctrl.del = 1'b1;
                ctrl.idx = XW'(in_pos - 5'd1);
              end
            end
            pss_pkg::ACT_READ_FWD, pss_pkg::ACT_READ_REV: begin
              if (count == '0) begin
                out_status_next = pss_pkg::ST_EMPTY;
              end else begin
                // Hold the result slot empty; the streaming state fills it.
                out_valid_next = 1'b0;
                state_next     = pss_pkg::FSM_READ;
                rd_k_next      = '0;
                rd_rev_next    = (act == pss_pkg::ACT_READ_REV);
                rd_n_next      = (count > CW'(MAXR)) ? CW'(MAXR) : count;
              end
            end
            default: begin
              out_status_next = pss_pkg::ST_OK;
            end
          endcase
          if (ctrl.ins) begin
            count_next = count + CW'(1);
          end else if (ctrl.del) begin
            count_next = count - CW'(1);
          end
          out_len_next = 5'(count_next);
        end
      end
      pss_pkg::FSM_READ: begin
        // Advance one value per free result slot.
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_status_next = pss_pkg::ST_OK;
          out_value_next  = vals[rd_slot];
          out_len_next    = 5'(count);
          out_last_next   = (rd_k + CW'(1) == rd_n);
          rd_k_next       = rd_k + CW'(1);
          if (rd_k + CW'(1) == rd_n) begin
            state_next = pss_pkg::FSM_IDLE;
          end
        end
      end
      default: begin
        state_next = pss_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pss_pkg::FSM_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_k      <= '0;
      rd_n      <= '0;
      rd_rev    <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      rd_k      <= rd_k_next;
      rd_n      <= rd_n_next;
      rd_rev    <= rd_rev_next;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
    out_len    <= out_len_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_len, out_value};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule
